>>> design/scs_pkg.sv
`default_nettype none

package scs_pkg;

  localparam int KEY_W          = 32;
  localparam int VAL_W          = 32;
  localparam int CFG_W          = 5;
  localparam int MIN_CAPACITY   = 2;
  localparam int RESET_CAPACITY = 16;

  // Request opcodes carried in the input tuser.
  localparam logic [1:0] OP_GET = 2'd0;
  localparam logic [1:0] OP_PUT = 2'd1;
  localparam logic [1:0] OP_DEL = 2'd2;
  localparam logic [1:0] OP_REF = 2'd3;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_MISS = 1'b1;

  // Commands broadcast from the sequencer to every cell.
  localparam logic [2:0] CELL_HOLD      = 3'd0;
  localparam logic [2:0] CELL_MATCH     = 3'd1;
  localparam logic [2:0] CELL_UPDATE    = 3'd2;
  localparam logic [2:0] CELL_SHIFT_HIT = 3'd3;
  localparam logic [2:0] CELL_SHIFT_ALL = 3'd4;
  localparam logic [2:0] CELL_ROTATE    = 3'd5;
  localparam logic [2:0] CELL_LOAD      = 3'd6;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    logic             refd;
    logic             valid;
  } entry_t;

  // Result gathered cell by cell from the head toward the end of the row.
  typedef struct packed {
    logic             seen;
    logic [VAL_W-1:0] value;
    logic             refd;
  } chain_t;

  typedef struct packed {
    logic [2:0]       op;
    logic             wr_val;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } cell_ctrl_t;

endpackage

`default_nettype wire

>>> design/scs_cell.sv
`default_nettype none

module scs_cell
  import scs_pkg::*;
#(
  parameter int IDX   = 0,
  parameter int CNT_W = 5
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cell_ctrl_t       ctrl_i,
  input  wire logic [CNT_W-1:0] count_i,
  input  wire entry_t           next_i,
  input  wire chain_t           chain_i,
  output entry_t                entry_o,
  output chain_t                chain_o,
  output logic                  hit_o
);

  logic [KEY_W-1:0] key_q;
  logic [VAL_W-1:0] value_q;
  logic             refd_q;
  logic             valid_q;
  logic             hit_q;
  entry_t           entry_d;
  logic             hit_d;
  logic             seen_incl;
  logic             at_tail;
  logic             below_tail;
  logic             at_count;
  entry_t           bus_entry;

  assign entry_o    = '{key: key_q, value: value_q, refd: refd_q, valid: valid_q};
  assign hit_o      = hit_q;
  assign seen_incl  = chain_i.seen | hit_q;

  assign chain_o.seen  = seen_incl;
  assign chain_o.value = chain_i.value | (hit_q ? value_q : {VAL_W{1'b0}});
  assign chain_o.refd  = chain_i.refd | (hit_q & refd_q);

  assign at_tail    = (CNT_W'(IDX + 1) == count_i);
  assign below_tail = (CNT_W'(IDX + 1) < count_i);
  assign at_count   = (CNT_W'(IDX) == count_i);
  assign bus_entry  = '{key: ctrl_i.key, value: ctrl_i.value, refd: 1'b0, valid: 1'b1};

  always_comb begin
    entry_d = entry_o;
    hit_d   = hit_q;
    unique case (ctrl_i.op)
      CELL_HOLD: begin
      end
      CELL_MATCH: begin
        hit_d = valid_q && (key_q == ctrl_i.key);
      end
      CELL_UPDATE: begin
        if (hit_q) begin
          entry_d.refd = 1'b1;
          if (ctrl_i.wr_val) begin
            entry_d.value = ctrl_i.value;
          end
        end
      end
      CELL_SHIFT_HIT: begin
        if (seen_incl) begin
          entry_d = next_i;
        end
      end
      CELL_SHIFT_ALL: begin
        entry_d = next_i;
      end
      CELL_ROTATE: begin
        // The head entry re-enters at the tail with its reference cleared.
        if (below_tail) begin
          entry_d = next_i;
        end else if (at_tail) begin
          entry_d = bus_entry;
        end
      end
      CELL_LOAD: begin
        if (at_count) begin
          entry_d = bus_entry;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      refd_q  <= 1'b0;
      valid_q <= 1'b0;
      hit_q   <= 1'b0;
    end else begin
      refd_q  <= entry_d.refd;
      valid_q <= entry_d.valid;
      hit_q   <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= entry_d.key;
    value_q <= entry_d.value;
  end

endmodule

`default_nettype wire

>>> design/second_chance_cache_set_top.sv
`default_nettype none

// Fully associative cache set with second-chance replacement.
// Requests arrive on the s_axis channel: tuser carries the opcode (get, put,
// delete, query reference bit), tdata carries the key and the put value.
// Each request yields exactly one result beat on m_axis: tuser is the status
// (miss flag), tdata the value of a get hit and the reference bit of a query.
// The capacity register is written through cfg_we_i/cfg_wdata_i; the user
// must write it only while idle, as the block itself does not enforce this.
// One request is worked on at a time. After the accept, the MATCH state loads
// the compare results into the cells and the EXEC state produces the result,
// which is registered into the result beat. A put of a new key goes on to the
// INSERT state for the append; when the set is full, it first passes through
// the EVICT state for up to entry count + 1 steps, each one shift of the cell row.
// The next request is accepted once the block is back in idle, even if the
// previous result beat is still waiting. A stalled receiver holds the result
// register, and a request that finishes meanwhile waits for it to drain.
// Reset empties the set, clears all reference bits and sets the capacity to
// 16, or MAX_ENTRIES if that is smaller.
module second_chance_cache_set_top
  import scs_pkg::*;
#(
  parameter int MAX_ENTRIES = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [CFG_W-1:0]  cfg_wdata_i,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [63:0]       s_axis_tdata,  // key[31:0], data_in[63:32]
  input  wire logic [1:0]        s_axis_tuser,  // opcode[1:0]
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic [39:0]            m_axis_tdata,  // data_out[31:0], ref_bit[32], zero pad
  output logic [0:0]             m_axis_tuser   // status[0]
);

  localparam int CNT_W     = $clog2(MAX_ENTRIES + 1);
  localparam int CAP_RESET = (RESET_CAPACITY > MAX_ENTRIES) ? MAX_ENTRIES : RESET_CAPACITY;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MATCH  = 3'd1;
  localparam logic [2:0] ST_EXEC   = 3'd2;
  localparam logic [2:0] ST_EVICT  = 3'd3;
  localparam logic [2:0] ST_INSERT = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] cap_q;
  logic [1:0]       req_op_q;
  logic [KEY_W-1:0] req_key_q;
  logic [VAL_W-1:0] req_data_q;

  logic             m_valid_q;
  logic             res_status_q, res_status_d;
  logic [VAL_W-1:0] res_data_q, res_data_d;
  logic             res_ref_q, res_ref_d;
  logic             out_load;
  logic             out_free;
  logic             in_accept;
  logic             hit;

  cell_ctrl_t       ctrl;
  entry_t           cell_entry [MAX_ENTRIES];
  entry_t           cell_next  [MAX_ENTRIES];
  chain_t           chain      [MAX_ENTRIES+1];
  logic [MAX_ENTRIES-1:0] hit_vec;
  logic [MAX_ENTRIES-1:0] valid_vec;

  assign chain[0] = '0;

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    if (g == MAX_ENTRIES - 1) begin : g_last
      assign cell_next[g] = '0;
    end else begin : g_mid
      assign cell_next[g] = cell_entry[g+1];
    end

    scs_cell #(
      .IDX   (g),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .count_i (count_q),
      .next_i  (cell_next[g]),
      .chain_i (chain[g]),
      .entry_o (cell_entry[g]),
      .chain_o (chain[g+1]),
      .hit_o   (hit_vec[g])
    );

    assign valid_vec[g] = cell_entry[g].valid;
  end

  assign hit           = chain[MAX_ENTRIES].seen;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {7'b0, res_ref_q, res_data_q};
  assign m_axis_tuser  = res_status_q;

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    out_load     = 1'b0;
    res_status_d = STATUS_OK;
    res_data_d   = '0;
    res_ref_d    = 1'b0;
    ctrl.op      = CELL_HOLD;
    ctrl.wr_val  = 1'b0;
    ctrl.key     = req_key_q;
    ctrl.value   = req_data_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_MATCH;
        end
      end
      ST_MATCH: begin
        ctrl.op = CELL_MATCH;
        state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (out_free) begin
          unique case (req_op_q)
            OP_GET: begin
              if (hit) begin
                ctrl.op = CELL_UPDATE;
              end
              out_load     = 1'b1;
              res_status_d = hit ? STATUS_OK : STATUS_MISS;
              res_data_d   = chain[MAX_ENTRIES].value;
              state_d      = ST_IDLE;
            end
            OP_PUT: begin
              if (hit) begin
                ctrl.op     = CELL_UPDATE;
                ctrl.wr_val = 1'b1;
                out_load    = 1'b1;
                state_d     = ST_IDLE;
              end else if (count_q >= cap_q) begin
                state_d = ST_EVICT;
              end else begin
                state_d = ST_INSERT;
              end
            end
            OP_DEL: begin
              if (hit) begin
                ctrl.op = CELL_SHIFT_HIT;
                count_d = count_q - CNT_W'(1);
              end
              out_load     = 1'b1;
              res_status_d = hit ? STATUS_OK : STATUS_MISS;
              state_d      = ST_IDLE;
            end
            OP_REF: begin
              out_load     = 1'b1;
              res_status_d = hit ? STATUS_OK : STATUS_MISS;
              res_ref_d    = chain[MAX_ENTRIES].refd;
              state_d      = ST_IDLE;
            end
            default: begin
            end
          endcase
        end
      end
      ST_EVICT: begin
        // One second-chance step per cycle, always on the head cell.
        if (!cell_entry[0].refd) begin
          ctrl.op = CELL_SHIFT_ALL;
          count_d = count_q - CNT_W'(1);
          state_d = ST_INSERT;
        end else begin
          ctrl.op    = CELL_ROTATE;
          ctrl.key   = cell_entry[0].key;
          ctrl.value = cell_entry[0].value;
        end
      end
      ST_INSERT: begin
        if (out_free) begin
          ctrl.op  = CELL_LOAD;
          count_d  = count_q + CNT_W'(1);
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      cap_q     <= CNT_W'(CAP_RESET);
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (cfg_we_i && (cfg_wdata_i >= CFG_W'(MIN_CAPACITY))) begin
        if (32'(cfg_wdata_i) > 32'(MAX_ENTRIES)) begin
          cap_q <= CNT_W'(MAX_ENTRIES);
        end else begin
          cap_q <= CNT_W'(cfg_wdata_i);
        end
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_op_q   <= s_axis_tuser;
      req_key_q  <= s_axis_tdata[31:0];
      req_data_q <= s_axis_tdata[63:32];
    end
    if (out_load) begin
      res_status_q <= res_status_d;
      res_data_q   <= res_data_d;
      res_ref_q    <= res_ref_d;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_ENTRIES))
    else $error("entry count exceeds the number of cells");

  a_valid_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_vec == MAX_ENTRIES'(({{MAX_ENTRIES{1'b0}}, 1'b1} << count_q) - 1'b1))
    else $error("valid cells are not the first count cells");

  a_single_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(hit_vec))
    else $error("key matched in more than one cell");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_INSERT && out_free) |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("append did not grow the entry count");

  a_result_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (state_q == ST_EXEC || state_q == ST_INSERT) && out_free)
    else $error("result loaded while the output register was busy");
`endif

endmodule

`default_nettype wire

>>> bench/tb.sv
module tb;
  import scs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_ENTRIES = 16;
  localparam int CYCLE_LIMIT = 250000;
  localparam int POOL_SIZE   = 24;

  typedef struct packed {
    logic             status;
    logic [VAL_W-1:0] data;
    logic             refbit;
  } reply_t;

  // Mirror of the cache set: lines in insertion order, head at index 0.
  class set_mirror;
    typedef struct {
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] value;
      bit               refd;
    } line_t;

    line_t       lines[$];
    reply_t      expected_replies[$];
    int unsigned capacity;
    int unsigned failures;
    int unsigned checked;
    int unsigned evictions;

    function new();
      capacity = (RESET_CAPACITY > MAX_ENTRIES) ? MAX_ENTRIES : RESET_CAPACITY;
    endfunction

    function void write_capacity(logic [CFG_W-1:0] v);
      if (v < MIN_CAPACITY) return;
      capacity = (v > MAX_ENTRIES) ? MAX_ENTRIES : v;
    endfunction

    function int find_line(logic [KEY_W-1:0] k);
      foreach (lines[i]) if (lines[i].key == k) return i;
      return -1;
    endfunction

    // Referenced heads lose their bit and go to the tail; the first
    // unreferenced head is dropped.
    function void evict_one();
      int    steps;
      line_t head;
      for (steps = 0; steps <= lines.size() && lines.size() > 0; steps++) begin
        if (!lines[0].refd) begin
          lines.delete(0);
          evictions++;
          return;
        end
        head = lines.pop_front();
        head.refd = 1'b0;
        lines.push_back(head);
      end
    endfunction

    function void note_request(logic [1:0] op, logic [KEY_W-1:0] key,
                               logic [VAL_W-1:0] data);
      reply_t r;
      int     idx;
      line_t  fresh;
      r = '0;
      idx = find_line(key);
      case (op)
        OP_GET: begin
          if (idx >= 0) begin
            lines[idx].refd = 1'b1;
            r.data = lines[idx].value;
          end else begin
            r.status = STATUS_MISS;
          end
        end
        OP_PUT: begin
          if (idx >= 0) begin
            lines[idx].value = data;
            lines[idx].refd = 1'b1;
          end else begin
            if (lines.size() >= capacity) evict_one();
            if (lines.size() < MAX_ENTRIES) begin
              fresh.key = key;
              fresh.value = data;
              fresh.refd = 1'b0;
              lines.push_back(fresh);
            end
          end
        end
        OP_DEL: begin
          if (idx >= 0) lines.delete(idx);
          else r.status = STATUS_MISS;
        end
        default: begin
          if (idx >= 0) r.refbit = lines[idx].refd;
          else r.status = STATUS_MISS;
        end
      endcase
      expected_replies.push_back(r);
    endfunction

    function void check_reply(reply_t got);
      reply_t want;
      if (expected_replies.size() == 0) begin
        failures++;
        $display("%0t: result beat with nothing outstanding, actual status %0b data %h ref %0b",
                 $time, got.status, got.data, got.refbit);
        return;
      end
      want = expected_replies.pop_front();
      checked++;
      if (got.status !== want.status) begin
        failures++;
        $display("%0t: status mismatch, expected %0b, actual %0b",
                 $time, want.status, got.status);
      end
      if (got.data !== want.data) begin
        failures++;
        $display("%0t: data_out mismatch, expected %h, actual %h",
                 $time, want.data, got.data);
      end
      if (got.refbit !== want.refbit) begin
        failures++;
        $display("%0t: ref_bit mismatch, expected %0b, actual %0b",
                 $time, want.refbit, got.refbit);
      end
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic [CFG_W-1:0] cfg_wdata_i = '0;
  logic             s_axis_tvalid = 1'b0;
  logic [63:0]      s_axis_tdata = '0;
  logic [1:0]       s_axis_tuser = '0;
  logic             m_axis_tready = 1'b0;
  wire              s_axis_tready;
  wire              m_axis_tvalid;
  wire  [39:0]      m_axis_tdata;
  wire  [0:0]       m_axis_tuser;

  set_mirror        mirror = new();
  bit               quiet = 1'b0;
  int               cycle_count = 0;
  int               ready_hold = 0;
  int               requests_sent = 0;
  int               capacity_writes = 0;
  logic [KEY_W-1:0] key_pool[POOL_SIZE];

  second_chance_cache_set_top #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
      $display("tb: failure");
      $finish;
    end
  end

  // Receiver alternates ready stretches with stall bursts of random length.
  always @(posedge clk_i) begin
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (quiet || $urandom_range(0, 2) != 0) begin
      m_axis_tready <= 1'b1;
      ready_hold <= $urandom_range(0, 14);
    end else begin
      m_axis_tready <= 1'b0;
      ready_hold <= $urandom_range(0, 5);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      mirror.check_reply('{status: m_axis_tuser[0], data: m_axis_tdata[31:0],
                           refbit: m_axis_tdata[32]});
    end
  end

  task automatic issue_request(logic [1:0] op, logic [KEY_W-1:0] key,
                               logic [VAL_W-1:0] data);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {data, key};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    mirror.note_request(op, key, data);
    requests_sent++;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  // The sender holds off until every result beat is back, so the write
  // lands while the set is idle.
  task automatic settle_and_write_capacity(logic [CFG_W-1:0] v);
    s_axis_tvalid <= 1'b0;
    while (mirror.expected_replies.size() != 0) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    mirror.write_capacity(v);
    capacity_writes++;
  endtask

  // Mostly well-formed traffic on a key pool a little larger than the
  // capacity, so hits, misses and evictions all stay frequent.
  task automatic run_mix(int count);
    int               i;
    int               r;
    int               span;
    logic [1:0]       op;
    logic [KEY_W-1:0] key;
    span = mirror.capacity + 4;
    if (span > POOL_SIZE) span = POOL_SIZE;
    for (i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      key = key_pool[$urandom_range(0, span - 1)];
      if (r < 8) begin
        op = 2'($urandom_range(0, 3));
        key = $urandom;
      end else if (r < 45) begin
        op = OP_PUT;
      end else if (r < 72) begin
        op = OP_GET;
      end else if (r < 86) begin
        op = OP_REF;
      end else begin
        op = OP_DEL;
      end
      issue_request(op, key, $urandom);
    end
  endtask

  initial begin
    logic [CFG_W-1:0] phase_caps[9];
    int               p;
    phase_caps = '{5'd31, 5'd2, 5'd5, 5'd0, 5'd16, 5'd3, 5'd17, 5'd9, 5'd2};
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (p = 2; p < POOL_SIZE; p++) key_pool[p] = $urandom;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Writes below the minimum capacity must leave the reset value alone.
    settle_and_write_capacity(5'd1);
    settle_and_write_capacity(5'd0);

    issue_request(OP_GET, 32'h0, 32'hFFFF_FFFF);
    issue_request(OP_REF, 32'h0, 32'h0);
    issue_request(OP_DEL, 32'hFFFF_FFFF, 32'h0);
    issue_request(OP_PUT, 32'h0, 32'hFFFF_FFFF);
    issue_request(OP_PUT, 32'hFFFF_FFFF, 32'h0);
    issue_request(OP_PUT, 32'h5, 32'h1234_5678);
    issue_request(OP_GET, 32'h0, 32'h0);
    issue_request(OP_REF, 32'h0, 32'h0);
    issue_request(OP_REF, 32'hFFFF_FFFF, 32'h0);
    issue_request(OP_PUT, 32'hFFFF_FFFF, 32'hA5A5_5A5A);
    issue_request(OP_DEL, 32'h0, 32'h0);
    issue_request(OP_GET, 32'h0, 32'h0);
    issue_request(OP_PUT, 32'h1, 32'h0000_0001);
    issue_request(OP_PUT, 32'h2, 32'h8000_0000);
    issue_request(OP_GET, 32'h5, 32'h0);

    // Capacity drops below the count: a new key evicts one and keeps the count.
    settle_and_write_capacity(5'd2);
    issue_request(OP_PUT, 32'h9, 32'hDEAD_BEEF);
    issue_request(OP_REF, 32'hFFFF_FFFF, 32'h0);
    issue_request(OP_GET, 32'h9, 32'h0);
    issue_request(OP_GET, 32'h1, 32'h0);
    issue_request(OP_GET, 32'h2, 32'h0);

    for (p = 0; p < 9; p++) begin
      settle_and_write_capacity(phase_caps[p]);
      if (p == 8) quiet = 1'b1;
      run_mix(61);
    end

    s_axis_tvalid <= 1'b0;
    while (mirror.expected_replies.size() != 0) @(posedge clk_i);
    repeat (MAX_ENTRIES + 8) @(posedge clk_i);

    $display("Ran %0d requests over %0d capacity writes (2 to 16, rejected and saturated).",
             requests_sent, capacity_writes);
    $display("Checked %0d result beats, %0d evictions predicted, %0d mismatches.",
             mirror.checked, mirror.evictions, mirror.failures);
    if (mirror.failures == 0 && mirror.expected_replies.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
